[rtl/prq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types and codes of the priority ready queue
// Widths, action and status codes, and queue level numbers.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int MaxThreads = 16;
  localparam int IdW        = 4;
  localparam int QIdxW      = $clog2(MaxThreads);
  localparam int CntW       = $clog2(MaxThreads + 1);
  localparam int NumLevels  = 3;

  typedef logic [IdW-1:0]   id_t;
  typedef logic [QIdxW-1:0] qidx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [1:0]       lvl_t;

  localparam lvl_t LvlHigh = 2'd0;
  localparam lvl_t LvlMid  = 2'd1;
  localparam lvl_t LvlLow  = 2'd2;
  localparam lvl_t LvlBad  = 2'd3;

  typedef enum logic [2:0] {
    ActCreate   = 3'd0,
    ActYield    = 3'd1,
    ActDispatch = 3'd2,
    ActWait     = 3'd3,
    ActFinish   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StBadPrio   = 3'd1,
    StAlready   = 3'd2,
    StEmpty     = 3'd3,
    StWaitRefus = 3'd4,
    StNoWaiter  = 3'd5,
    StIdsOut    = 3'd6,
    StUnknown   = 3'd7
  } status_e;

endpackage

[rtl/priority_ready_queue_with_join.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue_with_join: strict-priority thread ready queue
// Three FIFO ready queues (high, medium, low) with create, yield, dispatch,
// wait and finish actions, plus a one-waiter-per-thread join table.
// ----------------------------------------------------------------------------
// One action is taken per beat and answered by exactly one result beat. The
// block accepts a new action every cycle while the output is not stalled:
// the action is held in an input register, its whole read-modify-write on
// the flag vectors, the three register FIFOs and the id counter is done
// from that register, and the answer lands in an output register.
// Throughput is one action per cycle unless the output stalls. The input
// register advances whenever the output register is empty or being drained,
// which is the only thing that can stall intake. Status codes: ok, bad
// priority, already ready, empty, wait refused, no waiter, ids exhausted,
// unknown id. out_id is the new, dispatched or released id, else zero.
// Actions 5 to 7 are no-ops that answer ok with id zero.
module priority_ready_queue_with_join (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic [1:0]          priority_level_i,
  input  prq_pkg::id_t        thread_id_i,
  input  prq_pkg::id_t        target_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output prq_pkg::id_t        out_id_o
);
  import prq_pkg::*;

  // Input stage
  logic       in_valid_q;
  logic [2:0] action_q;
  lvl_t       prio_q;
  id_t        tid_q;
  id_t        tgt_q;

  // Output stage
  logic       out_valid_q;
  logic [2:0] status_q, status_d;
  id_t        out_id_q, out_id_d;

  // Scheduler state
  id_t                   queue_q [NumLevels][MaxThreads];
  qidx_t                 head_q  [NumLevels];
  cnt_t                  count_q [NumLevels];
  lvl_t                  tprio_q [MaxThreads];
  id_t                   waiter_q[MaxThreads];
  logic [MaxThreads-1:0] ready_q, blocked_q, wvalid_q;
  cnt_t                  next_id_q;

  logic advance, fire;

  // Update controls
  logic  push_en, push_ok, pop_en, pr_we, blk_set, blk_clr, wt_set, wt_clr;
  logic  id_inc;
  lvl_t  push_lvl, pop_lvl, pr_rd;
  id_t   push_id, pop_id, waiter_id, pr_rd_addr;
  qidx_t push_addr;
  logic  tid_known, tgt_known;

  // Handshake: drop the result beat when taken, advance the input stage
  // whenever the result register frees up.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  assign tid_known  = CntW'(tid_q) < next_id_q;
  assign tgt_known  = CntW'(tgt_q) < next_id_q;
  assign waiter_id  = waiter_q[tgt_q];
  // Only one priority lookup per action: finish looks up the waiter,
  // yield the yielding thread.
  assign pr_rd_addr = (action_q == ActFinish) ? waiter_id : tid_q;
  assign pr_rd      = tprio_q[pr_rd_addr];
  assign pop_id     = queue_q[pop_lvl][head_q[pop_lvl]];
  assign push_ok    = push_en && (count_q[push_lvl] < CntW'(MaxThreads));
  // Slot index wraps at the queue depth (a power of two).
  assign push_addr  = QIdxW'(head_q[push_lvl] + count_q[push_lvl][QIdxW-1:0]);

  always_comb begin
    status_d = StOk;
    out_id_d = '0;
    push_en  = 1'b0;
    push_lvl = LvlHigh;
    push_id  = tid_q;
    pop_en   = 1'b0;
    pop_lvl  = LvlHigh;
    pr_we    = 1'b0;
    blk_set  = 1'b0;
    blk_clr  = 1'b0;
    wt_set   = 1'b0;
    wt_clr   = 1'b0;
    id_inc   = 1'b0;
    unique case (action_q)
      ActCreate: begin
        if (prio_q == LvlBad) begin
          status_d = StBadPrio;
        end else if (next_id_q >= CntW'(MaxThreads)) begin
          status_d = StIdsOut;
        end else begin
          id_inc   = 1'b1;
          pr_we    = 1'b1;
          push_en  = 1'b1;
          push_lvl = prio_q;
          push_id  = next_id_q[IdW-1:0];
          out_id_d = next_id_q[IdW-1:0];
        end
      end
      ActYield: begin
        if (!tid_known) begin
          status_d = StUnknown;
        end else if (ready_q[tid_q] || blocked_q[tid_q]) begin
          status_d = StAlready;
        end else begin
          push_en  = 1'b1;
          push_lvl = pr_rd;
          push_id  = tid_q;
        end
      end
      ActDispatch: begin
        // Serve strictly high first.
        priority if (count_q[LvlHigh] != '0) begin
          pop_en  = 1'b1;
          pop_lvl = LvlHigh;
        end else if (count_q[LvlMid] != '0) begin
          pop_en  = 1'b1;
          pop_lvl = LvlMid;
        end else if (count_q[LvlLow] != '0) begin
          pop_en  = 1'b1;
          pop_lvl = LvlLow;
        end else begin
          pop_en  = 1'b0;
        end
        if (pop_en) begin
          out_id_d = pop_id;
        end else begin
          status_d = StEmpty;
        end
      end
      ActWait: begin
        if (!tid_known || !tgt_known) begin
          status_d = StUnknown;
        end else if (tgt_q == tid_q || wvalid_q[tgt_q] ||
                     ready_q[tid_q] || blocked_q[tid_q]) begin
          status_d = StWaitRefus;
        end else begin
          blk_set = 1'b1;
          wt_set  = 1'b1;
        end
      end
      ActFinish: begin
        if (!tgt_known) begin
          status_d = StUnknown;
        end else if (!wvalid_q[tgt_q]) begin
          status_d = StNoWaiter;
        end else begin
          // Release the waiter and requeue it unless already queued.
          wt_clr   = 1'b1;
          blk_clr  = 1'b1;
          push_en  = !ready_q[waiter_id];
          push_lvl = pr_rd;
          push_id  = waiter_id;
          out_id_d = waiter_id;
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '{default: '0};
      count_q     <= '{default: '0};
      ready_q     <= '0;
      blocked_q   <= '0;
      wvalid_q    <= '0;
      next_id_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        if (id_inc) begin
          next_id_q <= next_id_q + CntW'(1);
        end
        if (push_ok) begin
          count_q[push_lvl] <= count_q[push_lvl] + CntW'(1);
          ready_q[push_id]  <= 1'b1;
        end
        if (pop_en) begin
          count_q[pop_lvl] <= count_q[pop_lvl] - CntW'(1);
          head_q[pop_lvl]  <= head_q[pop_lvl] + QIdxW'(1);
          ready_q[pop_id]  <= 1'b0;
        end
        if (blk_set) begin
          blocked_q[tid_q] <= 1'b1;
        end
        if (blk_clr) begin
          blocked_q[waiter_id] <= 1'b0;
        end
        if (wt_set) begin
          wvalid_q[tgt_q] <= 1'b1;
        end
        if (wt_clr) begin
          wvalid_q[tgt_q] <= 1'b0;
        end
      end
    end
  end

  // Payload and table storage
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      prio_q   <= priority_level_i;
      tid_q    <= thread_id_i;
      tgt_q    <= target_id_i;
    end
    if (fire) begin
      status_q <= status_d;
      out_id_q <= out_id_d;
      if (push_ok) begin
        queue_q[push_lvl][push_addr] <= push_id;
      end
      if (pr_we) begin
        tprio_q[next_id_q[IdW-1:0]] <= prio_q;
      end
      if (wt_set) begin
        waiter_q[tgt_q] <= tid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_id_o    = out_id_q;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for priority_ready_queue_with_join
// Drives create, yield, dispatch, wait and finish beats with random gaps and
// checks every result beat against a scoreboard that tracks the three ready
// queues, the join table and the id counter.
// ----------------------------------------------------------------------------
module tb;
  import prq_pkg::*;

  localparam int ClkHalf      = 5;
  localparam int ResetCycles  = 12;
  localparam int RandomBeats  = 1600;
  localparam int IdleLimit    = 2000;
  localparam int DrainCycles  = 10;
  localparam int HoldOffAt    = 500;
  localparam int HoldOffLen   = 200;
  localparam int BurstFrom    = 1000;
  localparam int BurstTo      = 1200;

  // Action codes with no meaning: the block answers ok with id zero.
  localparam logic [2:0] ActSpareLo = 3'd5;
  localparam logic [2:0] ActSpareHi = 3'd7;

  typedef struct packed {
    status_e status;
    id_t     out_id;
  } answer_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the scheduler state plus the answers still owed.
  // --------------------------------------------------------------------------
  class ready_queue_scoreboard;
    id_t                   fifo_mem [NumLevels][MaxThreads];
    qidx_t                 head_ptr [NumLevels];
    cnt_t                  fill     [NumLevels];
    lvl_t                  level_of [MaxThreads];
    id_t                   waiter_of[MaxThreads];
    logic [MaxThreads-1:0] is_ready;
    logic [MaxThreads-1:0] is_blocked;
    logic [MaxThreads-1:0] has_waiter;
    cnt_t                  id_count;
    answer_t               owed[$];
    int                    errors;

    function void clear_state();
      for (int i = 0; i < NumLevels; i++) begin
        head_ptr[i] = '0;
        fill[i]     = '0;
      end
      is_ready   = '0;
      is_blocked = '0;
      has_waiter = '0;
      id_count   = '0;
      errors     = 0;
      owed.delete();
    endfunction

    // Append to the tail of one level; a thread is never queued twice.
    function void enqueue(lvl_t lv, id_t id);
      qidx_t slot;
      if (fill[lv] >= MaxThreads) return;
      slot = head_ptr[lv] + qidx_t'(fill[lv]);
      fifo_mem[lv][slot] = id;
      fill[lv]++;
      is_ready[id] = 1'b1;
    endfunction

    // Work out the answer to one accepted action beat and queue it.
    function void note_action(logic [2:0] act, logic [1:0] prio, id_t tid, id_t tgt);
      answer_t ans;
      id_t     w;
      ans.status = StOk;
      ans.out_id = '0;
      case (act)
        ActCreate: begin
          if (prio == LvlBad) begin
            ans.status = StBadPrio;
          end else if (id_count >= MaxThreads) begin
            ans.status = StIdsOut;
          end else begin
            ans.out_id = id_t'(id_count);
            level_of[ans.out_id] = prio;
            enqueue(prio, ans.out_id);
            id_count++;
          end
        end
        ActYield: begin
          if (tid >= id_count) begin
            ans.status = StUnknown;
          end else if (is_ready[tid] || is_blocked[tid]) begin
            ans.status = StAlready;
          end else begin
            enqueue(level_of[tid], tid);
          end
        end
        ActDispatch: begin
          ans.status = StEmpty;
          // Serve strictly high first.
          for (int i = 0; i < NumLevels; i++) begin
            if (ans.status == StEmpty && fill[i] != 0) begin
              ans.out_id = fifo_mem[i][head_ptr[i]];
              head_ptr[i]++;
              fill[i]--;
              is_ready[ans.out_id] = 1'b0;
              ans.status = StOk;
            end
          end
        end
        ActWait: begin
          if (tid >= id_count || tgt >= id_count) begin
            ans.status = StUnknown;
          end else if (tgt == tid || has_waiter[tgt] || is_ready[tid] || is_blocked[tid]) begin
            ans.status = StWaitRefus;
          end else begin
            is_blocked[tid] = 1'b1;
            has_waiter[tgt] = 1'b1;
            waiter_of[tgt]  = tid;
          end
        end
        ActFinish: begin
          if (tgt >= id_count) begin
            ans.status = StUnknown;
          end else if (!has_waiter[tgt]) begin
            ans.status = StNoWaiter;
          end else begin
            // Release the waiter; the finished thread itself stays known.
            w = waiter_of[tgt];
            has_waiter[tgt] = 1'b0;
            is_blocked[w]   = 1'b0;
            if (!is_ready[w]) enqueue(level_of[w], w);
            ans.out_id = w;
          end
        end
        default: ;
      endcase
      owed.push_back(ans);
    endfunction

    // Compare one result beat with the oldest owed answer.
    function void check_result(logic [2:0] st, id_t oid);
      answer_t ans;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: status %0d out_id %0d", st, oid);
        errors++;
        return;
      end
      ans = owed.pop_front();
      if (st !== ans.status) begin
        $error("status: expected %0d, actual %0d", ans.status, st);
        errors++;
      end
      if (oid !== ans.out_id) begin
        $error("out_id: expected %0d, actual %0d", ans.out_id, oid);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // A known thread that is neither queued nor blocked, else any id.
    function id_t pick_idle_thread();
      id_t pool[$];
      for (int i = 0; i < MaxThreads; i++) begin
        if (i < id_count && !is_ready[i] && !is_blocked[i]) pool.push_back(id_t'(i));
      end
      if (pool.size() == 0) return id_t'($urandom_range(MaxThreads - 1));
      return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // A thread that has a waiter parked on it, else any id.
    function id_t pick_joined_thread();
      id_t pool[$];
      for (int i = 0; i < MaxThreads; i++) begin
        if (has_waiter[i]) pool.push_back(id_t'(i));
      end
      if (pool.size() == 0) return id_t'($urandom_range(MaxThreads - 1));
      return pool[$urandom_range(pool.size() - 1)];
    endfunction

    // Any thread that exists, else any id.
    function id_t pick_known_thread();
      if (id_count == 0) return id_t'($urandom_range(MaxThreads - 1));
      return id_t'($urandom_range(id_count - 1));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic [2:0] action_i         = '0;
  logic [1:0] priority_level_i = '0;
  id_t        thread_id_i      = '0;
  id_t        target_id_i      = '0;
  logic       out_ready_i      = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [2:0] status_o;
  id_t        out_id_o;

  ready_queue_scoreboard sched_sb;
  int                    beats_in   = 0;
  int                    idle_count = 0;

  always #(ClkHalf) clk_i = ~clk_i;

  priority_ready_queue_with_join u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .priority_level_i (priority_level_i),
    .thread_id_i      (thread_id_i),
    .target_id_i      (target_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .out_id_o         (out_id_o)
  );

  // --------------------------------------------------------------------------
  // Monitor: note every accepted action beat first, then check the result
  // beat, so the order holds even if the block answered in the same cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sched_sb.note_action(action_i, priority_level_i, thread_id_i, target_id_i);
        beats_in++;
      end
      if (out_valid_o && out_ready_i) begin
        sched_sb.check_result(status_o, out_id_o);
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Stretch in which neither side idles.
  function automatic bit in_burst();
    return beats_in >= BurstFrom && beats_in < BurstTo;
  endfunction

  // --------------------------------------------------------------------------
  // Result side pacing: random on and off stretches, plus one long hold-off
  // that lets the block fill up and stall its input.
  // --------------------------------------------------------------------------
  initial begin : result_pacing
    int  run_len;
    int  off_len;
    bit  held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && beats_in >= HoldOffAt) begin
        held = 1'b1;
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HoldOffLen) @(negedge clk_i);
      end
      run_len = $urandom_range(1, 24);
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (run_len - 1) @(negedge clk_i);
      off_len = in_burst() ? 0 : gap_len();
      if (off_len > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (off_len - 1) @(negedge clk_i);
      end
    end
  end

  // Offer one action beat after an optional gap and hold it until accepted.
  // With no gap, valid stays high and only the payload advances.
  task automatic drive_beat(input logic [2:0] act, input logic [1:0] prio,
                            input id_t tid, input id_t tgt);
    int gap;
    gap = in_burst() ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    action_i         <= act;
    priority_level_i <= prio;
    thread_id_i      <= tid;
    target_id_i      <= tgt;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Build one random beat, steered by the scoreboard toward sequences that
  // actually move threads between queued, running and blocked.
  task automatic drive_random_beat();
    logic [2:0] act;
    logic [1:0] prio;
    id_t        tid;
    id_t        tgt;
    int         r;
    int         create_w;
    prio     = 2'($urandom_range(3));
    tid      = id_t'($urandom_range(MaxThreads - 1));
    tgt      = id_t'($urandom_range(MaxThreads - 1));
    create_w = (sched_sb.id_count < MaxThreads) ? 30 : 5;
    r        = $urandom_range(99);
    if (r < create_w) begin
      act  = ActCreate;
      prio = ($urandom_range(9) == 0) ? LvlBad : 2'($urandom_range(LvlLow));
    end else if (r < create_w + 22) begin
      act = ActDispatch;
    end else if (r < create_w + 40) begin
      act = ActYield;
      if ($urandom_range(3) != 0) tid = sched_sb.pick_idle_thread();
    end else if (r < create_w + 60) begin
      act = ActWait;
      if ($urandom_range(3) != 0) tid = sched_sb.pick_idle_thread();
      if ($urandom_range(3) != 0) tgt = sched_sb.pick_known_thread();
    end else if (r < 97) begin
      act = ActFinish;
      if ($urandom_range(9) < 7) tgt = sched_sb.pick_joined_thread();
    end else begin
      act = 3'($urandom_range(ActSpareLo, ActSpareHi));
    end
    drive_beat(act, prio, tid, tgt);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    sched_sb = new;
    sched_sb.clear_state();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: the error paths that need no thread, first while nothing exists yet.
    drive_beat(ActCreate,   LvlBad,  4'd0,  4'd0);   // bad priority wins
    drive_beat(ActYield,    LvlHigh, 4'd0,  4'd0);   // unknown thread
    drive_beat(ActDispatch, LvlHigh, 4'd15, 4'd15);  // all queues empty
    drive_beat(ActWait,     LvlHigh, 4'd0,  4'd15);  // unknown thread
    drive_beat(ActFinish,   LvlHigh, 4'd0,  4'd15);  // unknown target
    drive_beat(ActSpareLo,  LvlBad,  4'd15, 4'd15);  // spare codes do nothing
    drive_beat(ActSpareHi,  LvlHigh, 4'd0,  4'd0);
    // One thread per level, one extra at low.
    drive_beat(ActCreate,   LvlHigh, 4'd0,  4'd0);   // id 0
    drive_beat(ActCreate,   LvlMid,  4'd0,  4'd0);   // id 1
    drive_beat(ActCreate,   LvlLow,  4'd0,  4'd0);   // id 2
    drive_beat(ActCreate,   LvlLow,  4'd0,  4'd0);   // id 3
    drive_beat(ActYield,    LvlHigh, 4'd0,  4'd0);   // already queued
    drive_beat(ActDispatch, LvlHigh, 4'd0,  4'd0);   // high first
    drive_beat(ActDispatch, LvlHigh, 4'd0,  4'd0);   // then medium
    drive_beat(ActDispatch, LvlHigh, 4'd0,  4'd0);   // then low
    drive_beat(ActWait,     LvlHigh, 4'd0,  4'd0);   // wait on itself
    drive_beat(ActWait,     LvlHigh, 4'd0,  4'd1);   // 0 joins 1
    drive_beat(ActWait,     LvlHigh, 4'd2,  4'd1);   // 1 already has a waiter
    drive_beat(ActWait,     LvlHigh, 4'd3,  4'd2);   // waiter is queued
    drive_beat(ActWait,     LvlHigh, 4'd0,  4'd2);   // waiter is blocked
    drive_beat(ActYield,    LvlHigh, 4'd0,  4'd0);   // blocked counts as ready
    drive_beat(ActFinish,   LvlHigh, 4'd0,  4'd2);   // no waiter on 2
    drive_beat(ActFinish,   LvlHigh, 4'd0,  4'd1);   // release 0
    drive_beat(ActFinish,   LvlHigh, 4'd0,  4'd1);   // target stays known
    drive_beat(ActYield,    LvlHigh, 4'd1,  4'd0);   // requeue 1 at medium

    // Random traffic; ids run out partway through and stay exhausted.
    for (int n = 0; n < RandomBeats; n++) begin
      drive_random_beat();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then keep the clock running so the pipeline can show any extra beat.
    while (sched_sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sched_sb.errors == 0 && sched_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
